### rtl/rfaf_pkg.sv
package rfaf_pkg;

    localparam int CFG_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int SEQ_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SESSION_ACTIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_BSSID      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_AP_ADDRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVACY_ON       = 3'd4;

    // Verdict codes.
    localparam logic [3:0] V_REORDER   = 4'd0;
    localparam logic [3:0] V_DELIVER   = 4'd1;
    localparam logic [3:0] V_INACTIVE  = 4'd2;
    localparam logic [3:0] V_FOREIGN   = 4'd3;
    localparam logic [3:0] V_INTEGRITY = 4'd4;
    localparam logic [3:0] V_NOSTA     = 4'd5;
    localparam logic [3:0] V_LATE      = 4'd6;
    localparam logic [3:0] V_CRYPTO    = 4'd7;
    localparam logic [3:0] V_DUP       = 4'd8;

    localparam int GROUP_BIT = 40;
    localparam logic [15:0] WINDOW_UNSET = 16'hFFFF;

    typedef struct packed {
        logic [47:0]      frame_bssid;
        logic [47:0]      transmitter;
        logic [47:0]      receiver;
        logic             integrity_error;
        logic             is_qos;
        logic [3:0]       tid;
        logic [SEQ_W-1:0] seq_num;
        logic             encrypted;
        logic             hw_decrypted;
        logic             station_known;
        logic             reorder_enabled;
        logic [15:0]      window_start;
    } item_t;

    typedef struct packed {
        logic [3:0] verdict;
        logic [3:0] out_tid;
    } result_t;

endpackage

### rtl/rfaf_seq_cache.sv
module rfaf_seq_cache
    import rfaf_pkg::*;
#(
    parameter int CACHE_DEPTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SEQ_W-1:0] seq,
    input  logic             record,
    output logic             hit
);

    localparam int SLOT_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_DEPTH - 1);

    logic [SEQ_W-1:0]  entry_reg [CACHE_DEPTH];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [CACHE_DEPTH-1:0] match;

    // Every entry is compared in parallel against the incoming sequence.
    always_comb
    begin
        for (int i = 0; i < CACHE_DEPTH; i++)
        begin
            match[i] = (entry_reg[i] == seq);
        end
    end

    assign hit = |match;
    assign slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            for (int i = 0; i < CACHE_DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (record)
        begin
            entry_reg[slot_reg] <= seq;
            slot_reg            <= slot_next;
        end
    end

endmodule

### rtl/rx_frame_admission_filter_core.sv
// A word accepted into the input register moves into the result register
// when that register is empty or its result is being taken.
// Throughput: one word per cycle if result_stall is low; input and result
// registers form a two-deep buffer, so input is taken while a result waits.
// Reset (rst_n, async, active low) clears all configuration registers,
// empties both stages and fills the sequence cache with zeros.
module rx_frame_admission_filter_core
    import rfaf_pkg::*;
#(
    parameter int CACHE_DEPTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic        session_active_reg;
    logic [47:0] bound_bssid_reg;
    logic [47:0] bound_ap_address_reg;
    logic [47:0] own_address_reg;
    logic        privacy_on_reg;

    logic    s1_valid_reg;
    item_t   s1_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic       out_free;
    logic       s1_move;
    logic       seq_hit;
    logic       to_cache;
    logic       record;
    logic       foreign;
    logic       late;
    logic       undecrypted;
    logic [SEQ_W-1:0] seq_diff;
    logic [3:0] verdict_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_active_reg   <= 1'b0;
            bound_bssid_reg      <= '0;
            bound_ap_address_reg <= '0;
            own_address_reg      <= '0;
            privacy_on_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SESSION_ACTIVE:   session_active_reg   <= cfg_data[0];
                REG_BOUND_BSSID:      bound_bssid_reg      <= cfg_data[47:0];
                REG_BOUND_AP_ADDRESS: bound_ap_address_reg <= cfg_data[47:0];
                REG_OWN_ADDRESS:      own_address_reg      <= cfg_data[47:0];
                REG_PRIVACY_ON:       privacy_on_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees up when empty or being taken.
    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_move    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;

    always_comb
    begin
        foreign = (s1_reg.frame_bssid != bound_bssid_reg)
               || (s1_reg.transmitter != bound_ap_address_reg)
               || (!s1_reg.receiver[GROUP_BIT] && (s1_reg.receiver != own_address_reg));
        seq_diff = s1_reg.seq_num - s1_reg.window_start[SEQ_W-1:0];
        late = s1_reg.reorder_enabled && (s1_reg.window_start != WINDOW_UNSET)
            && seq_diff[SEQ_W-1];
        undecrypted = s1_reg.encrypted && !s1_reg.hw_decrypted;
        to_cache = 1'b0;

        if (!session_active_reg)
        begin
            verdict_next = V_INACTIVE;
        end
        else if (foreign)
        begin
            verdict_next = V_FOREIGN;
        end
        else if (s1_reg.integrity_error)
        begin
            verdict_next = V_INTEGRITY;
        end
        else if (!s1_reg.station_known)
        begin
            verdict_next = V_NOSTA;
        end
        else if (s1_reg.is_qos)
        begin
            if (late)
            begin
                verdict_next = V_LATE;
            end
            else if (undecrypted && privacy_on_reg)
            begin
                verdict_next = V_CRYPTO;
            end
            else
            begin
                verdict_next = V_REORDER;
            end
        end
        else
        begin
            to_cache = 1'b1;
            if (seq_hit)
            begin
                verdict_next = V_DUP;
            end
            else if (undecrypted)
            begin
                verdict_next = V_CRYPTO;
            end
            else
            begin
                verdict_next = V_DELIVER;
            end
        end
    end

    // A fresh non-QoS sequence past early checks is recorded as it leaves s1.
    assign record = s1_move && to_cache && !seq_hit;

    rfaf_seq_cache #(
        .CACHE_DEPTH(CACHE_DEPTH)
    ) u_seq_cache (
        .clk    (clk),
        .rst_n  (rst_n),
        .seq    (s1_reg.seq_num),
        .record (record),
        .hit    (seq_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_reg <= item;
        end
        if (s1_move)
        begin
            out_reg.verdict <= verdict_next;
            out_reg.out_tid <= s1_reg.tid;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/rfaf_checker.sv
module rfaf_checker
    import rfaf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // A waiting result holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A new result must follow an input word taken in through the input register.
    a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
        else $error("result appeared without a matching input word");

    // With the result register empty the block never pushes back.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled while the result register is empty");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.verdict <= V_DUP)
        else $error("undefined verdict code");

endmodule

bind rx_frame_admission_filter_core rfaf_checker u_rfaf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### dv/tb_rx_frame_admission_filter_core.sv
`timescale 1ns / 1ps

module tb_rx_frame_admission_filter_core;

    import rfaf_pkg::*;

    localparam int RING_DEPTH = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam logic [47:0] ALL_ONES48 = 48'hFFFF_FFFF_FFFF;

    typedef enum int
    {
        GAP_S33_R70,
        GAP_S70_R33,
        GAP_NONE
    } idle_plan_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Shadow copy of the configuration and of the duplicate ring.
    logic        cfg_session = 1'b0;
    logic [47:0] cfg_bssid = '0;
    logic [47:0] cfg_ap = '0;
    logic [47:0] cfg_own = '0;
    logic        cfg_privacy = 1'b0;
    logic [SEQ_W-1:0] seen_seq_ring [RING_DEPTH];
    int          ring_ptr = 0;

    item_t       pending_frames[$];
    result_t     expected_verdicts[$];
    idle_plan_t  idle_plan = GAP_S33_R70;
    logic        hold_active = 1'b0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    event        start_holdoff;

    rx_frame_admission_filter_core #(
        .CACHE_DEPTH(RING_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            seen_seq_ring[i] = '0;
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic bit sender_waits();
        case (idle_plan)
            GAP_S33_R70: return $urandom_range(0, 99) < 33;
            GAP_S70_R33: return $urandom_range(0, 99) < 70;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_waits();
        case (idle_plan)
            GAP_S33_R70: return $urandom_range(0, 99) < 70;
            GAP_S70_R33: return $urandom_range(0, 99) < 33;
            default:     return 1'b0;
        endcase
    endfunction

    // Computes the verdict of one frame and updates the duplicate ring.
    function automatic result_t predict_verdict(input item_t f);
        result_t          r;
        logic [SEQ_W-1:0] seq_gap;
        logic             hit;
        r.out_tid = f.tid;
        hit = 1'b0;
        seq_gap = f.seq_num - f.window_start[SEQ_W-1:0];
        if (!cfg_session)
            r.verdict = V_INACTIVE;
        else if (f.frame_bssid != cfg_bssid || f.transmitter != cfg_ap ||
                 (!f.receiver[GROUP_BIT] && f.receiver != cfg_own))
            r.verdict = V_FOREIGN;
        else if (f.integrity_error)
            r.verdict = V_INTEGRITY;
        else if (!f.station_known)
            r.verdict = V_NOSTA;
        else if (f.is_qos)
        begin
            if (f.reorder_enabled && f.window_start != WINDOW_UNSET && seq_gap[SEQ_W-1])
                r.verdict = V_LATE;
            else if (f.encrypted && !f.hw_decrypted && cfg_privacy)
                r.verdict = V_CRYPTO;
            else
                r.verdict = V_REORDER;
        end
        else
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                if (seen_seq_ring[i] == f.seq_num)
                    hit = 1'b1;
            end
            if (hit)
                r.verdict = V_DUP;
            else
            begin
                // A new sequence is recorded even when the frame is then dropped.
                seen_seq_ring[ring_ptr] = f.seq_num;
                ring_ptr = (ring_ptr == RING_DEPTH - 1) ? 0 : ring_ptr + 1;
                r.verdict = (f.encrypted && !f.hw_decrypted) ? V_CRYPTO : V_DELIVER;
            end
        end
        return r;
    endfunction

    // A frame that passes every early check under the current settings.
    function automatic item_t good_frame();
        item_t f;
        f = '0;
        f.frame_bssid = cfg_bssid;
        f.transmitter = cfg_ap;
        f.receiver = cfg_own;
        f.station_known = 1'b1;
        f.window_start = WINDOW_UNSET;
        f.tid = 4'($urandom_range(0, 15));
        return f;
    endfunction

    function automatic item_t random_frame();
        item_t       f;
        int          pick;
        int          b;
        logic [3:0]  hi;
        logic [11:0] offs;
        f = good_frame();
        f.is_qos = 1'($urandom_range(0, 1));
        // Non-QoS sequences come mostly from a small pool so the ring gets hits.
        if (!f.is_qos && $urandom_range(0, 99) < 60)
            f.seq_num = 12'($urandom_range(0, 11));
        else
            f.seq_num = 12'($urandom_range(0, 4095));
        f.encrypted = 1'($urandom_range(0, 1));
        f.hw_decrypted = 1'($urandom_range(0, 1));
        f.reorder_enabled = 1'($urandom_range(0, 1));
        f.integrity_error = $urandom_range(0, 99) < 6;
        f.station_known = $urandom_range(0, 99) >= 6;
        if ($urandom_range(0, 99) < 30)
        begin
            f.receiver = rand48();
            f.receiver[GROUP_BIT] = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 25)
            f.window_start = WINDOW_UNSET;
        else if (pick < 65)
        begin
            case ($urandom_range(0, 4))
                0:       offs = 12'd2047;
                1:       offs = 12'd2048;
                2:       offs = 12'd0;
                3:       offs = 12'd4095;
                default: offs = 12'($urandom_range(0, 4095));
            endcase
            hi = 4'($urandom_range(0, 15));
            f.window_start = {hi, f.seq_num - offs};
        end
        else
            f.window_start = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        b = $urandom_range(0, 47);
        if (pick < 5)
            f.frame_bssid = rand48();
        else if (pick < 10)
            f.transmitter = rand48();
        else if (pick < 15)
            f.receiver = rand48();
        else if (pick < 18)
            f.frame_bssid[b] = ~f.frame_bssid[b];
        else if (pick < 21)
            f.transmitter[b] = ~f.transmitter[b];
        else if (pick < 24)
            f.receiver[b] = ~f.receiver[b];
        return f;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_SESSION_ACTIVE:   cfg_session = data[0];
            REG_BOUND_BSSID:      cfg_bssid = data;
            REG_BOUND_AP_ADDRESS: cfg_ap = data;
            REG_OWN_ADDRESS:      cfg_own = data;
            REG_PRIVACY_ON:       cfg_privacy = data[0];
            default:              ;
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic program_session(input logic active, input logic [47:0] bssid,
                                   input logic [47:0] ap, input logic [47:0] own,
                                   input logic privacy);
        logic [47:0] d;
        // One-bit registers get random upper bits, which must be ignored.
        d = rand48();
        d[0] = active;
        write_reg(REG_SESSION_ACTIVE, d);
        write_reg(REG_BOUND_BSSID, bssid);
        write_reg(REG_BOUND_AP_ADDRESS, ap);
        write_reg(REG_OWN_ADDRESS, own);
        d = rand48();
        d[0] = privacy;
        write_reg(REG_PRIVACY_ON, d);
    endtask

    task automatic wait_all_done();
        while (pending_frames.size() != 0 || item_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_round(input idle_plan_t plan, input int count, input bit squeeze);
        @(negedge clk);
        idle_plan = plan;
        if (squeeze)
            -> start_holdoff;
        repeat (count) pending_frames.push_back(random_frame());
        wait_all_done();
    endtask

    // Driver: offers frames from the pending queue and predicts each accepted one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_verdicts.push_back(predict_verdict(item));
            if (!item_valid || !item_stall)
            begin
                if (pending_frames.size() != 0 && !sender_waits())
                begin
                    item <= pending_frames.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: verdict %0d tid %0d",
                                 result.verdict, result.out_tid);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result.verdict !== want.verdict || result.out_tid !== want.out_tid)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected verdict %0d tid %0d, got verdict %0d tid %0d",
                                     want.verdict, want.out_tid, result.verdict, result.out_tid);
                    end
                end
            end
            result_stall <= hold_active || receiver_waits();
        end
    end

    // Long receiver hold-off so the block fills and stalls its input.
    initial
    begin
        forever
        begin
            @(start_holdoff);
            @(posedge clk);
            hold_active <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("** rx_frame_admission_filter_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        item_t f;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the session is inactive, so every frame is dropped.
        run_round(GAP_S33_R70, 2, 1'b0);

        program_session(1'b1, rand48(), rand48(), rand48(), 1'b1);
        @(negedge clk);
        // Fresh ring holds zeros, so sequence 0 is a duplicate.
        f = good_frame(); f.seq_num = 12'd0; f.tid = 4'd0; pending_frames.push_back(f);
        f = good_frame(); f.seq_num = 12'd5; f.tid = 4'd15; pending_frames.push_back(f);
        f = good_frame(); f.seq_num = 12'd5; pending_frames.push_back(f);
        // Undecrypted non-QoS frame is dropped but still recorded.
        f = good_frame(); f.seq_num = 12'd6; f.encrypted = 1'b1; pending_frames.push_back(f);
        f = good_frame(); f.seq_num = 12'd6; pending_frames.push_back(f);
        f = good_frame(); f.seq_num = 12'd7; f.encrypted = 1'b1; f.hw_decrypted = 1'b1;
        pending_frames.push_back(f);
        f = good_frame(); f.seq_num = 12'd8; f.frame_bssid = ~cfg_bssid; pending_frames.push_back(f);
        f = good_frame(); f.seq_num = 12'd8; f.transmitter = ~cfg_ap; pending_frames.push_back(f);
        f = good_frame(); f.seq_num = 12'd8; f.receiver = ~cfg_own;
        f.receiver[GROUP_BIT] = 1'b0; pending_frames.push_back(f);
        // Group receiver passes the address test whatever its other bits are.
        f = good_frame(); f.seq_num = 12'd4095; f.receiver = rand48();
        f.receiver[GROUP_BIT] = 1'b1; pending_frames.push_back(f);
        f = good_frame(); f.integrity_error = 1'b1; pending_frames.push_back(f);
        f = good_frame(); f.station_known = 1'b0; pending_frames.push_back(f);
        f = good_frame(); f.is_qos = 1'b1; f.reorder_enabled = 1'b1; f.seq_num = 12'd0;
        pending_frames.push_back(f);
        f = good_frame(); f.is_qos = 1'b1; f.reorder_enabled = 1'b1;
        f.window_start = 16'd100; f.seq_num = 12'd100; pending_frames.push_back(f);
        f.seq_num = 12'd2147; pending_frames.push_back(f);
        f.seq_num = 12'd2148; pending_frames.push_back(f);
        f.seq_num = 12'd99; pending_frames.push_back(f);
        // Only the low twelve bits of the window start enter the sequence distance.
        f.window_start = 16'hF064; pending_frames.push_back(f);
        f.reorder_enabled = 1'b0; pending_frames.push_back(f);
        f = good_frame(); f.is_qos = 1'b1; f.encrypted = 1'b1; f.tid = 4'd15;
        pending_frames.push_back(f);
        f.hw_decrypted = 1'b1; pending_frames.push_back(f);
        f = good_frame(); f.seq_num = 12'd4095; pending_frames.push_back(f);
        wait_all_done();

        program_session(1'b1, rand48(), rand48(), rand48(), 1'b1);
        run_round(GAP_S33_R70, 140, 1'b1);
        program_session(1'b1, ALL_ONES48, ALL_ONES48, ALL_ONES48, 1'b0);
        run_round(GAP_S33_R70, 140, 1'b0);
        program_session(1'b1, '0, '0, '0, 1'b1);
        run_round(GAP_S70_R33, 140, 1'b0);
        program_session(1'b1, rand48(), rand48(), rand48(), 1'b0);
        run_round(GAP_S70_R33, 140, 1'b1);
        program_session(1'b0, rand48(), rand48(), rand48(), 1'b1);
        run_round(GAP_NONE, 30, 1'b0);
        program_session(1'b1, rand48(), rand48(), rand48(), 1'b1);
        run_round(GAP_NONE, 160, 1'b1);

        if (fail_count == 0)
            $display("** rx_frame_admission_filter_core: PASSED **");
        else
            $display("** rx_frame_admission_filter_core: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/rfaf_pkg.sv
rtl/rfaf_seq_cache.sv
rtl/rx_frame_admission_filter_core.sv
rtl/rfaf_checker.sv
dv/tb_rx_frame_admission_filter_core.sv
